FILE: sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder unit.
package u8u16_pkg;

	localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
	localparam int unsigned MAX_RESULTS = 2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        run_last;
		logic        string_end;
	} out_item_t;

	typedef struct packed {
		logic [1:0]                       count;
		out_item_t [MAX_RESULTS - 1:0]    items;
	} dec_res_t;

endpackage

FILE: sv/u8u16_stream_if.sv
// Valid/ready stream interface used by both channels of the decoder unit.
interface u8u16_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: sv/u8u16_decode.sv
// Decode logic and held-sequence state for the byte in the input register.
module u8u16_decode
	import u8u16_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item_s1,
	input  logic     advance,
	output dec_res_t res
);

	typedef enum logic [1:0] {
		KIND_NONE         = 2'd0,
		KIND_TWO          = 2'd1,
		KIND_THREE        = 2'd2,
		KIND_THREE_SECOND = 2'd3
	} kind_t;

	kind_t      kind_q;
	kind_t      kind_next;
	logic [7:0] held_lead_q;
	logic [7:0] held_second_q;
	logic       start_emit;
	logic [15:0] start_unit;
	kind_t      start_kind;
	logic       start_last;

	always_comb begin
		start_last = item_s1.string_last || (kind_q == KIND_THREE);
		start_emit = 1'b1;
		start_kind = KIND_NONE;
		start_unit = REPLACEMENT_UNIT;
		if (!item_s1.in_byte[7]) begin
			start_unit = {8'h00, item_s1.in_byte};
		end else if (item_s1.in_byte[7:4] == 4'hE && !start_last) begin
			start_emit = 1'b0;
			start_kind = KIND_THREE;
		end else if (item_s1.in_byte[7:5] == 3'b110 && !start_last) begin
			start_emit = 1'b0;
			start_kind = KIND_TWO;
		end
	end

	always_comb begin
		res = '0;
		kind_next = KIND_NONE;
		case (kind_q)
			KIND_TWO: begin
				res.count = 2'd1;
				res.items[0] = '{code_unit: {5'd0, held_lead_q[4:0], item_s1.in_byte[5:0]},
					run_last: 1'b1, string_end: item_s1.string_last};
			end
			KIND_THREE: begin
				if (item_s1.string_last) begin
					res.count = 2'd2;
					res.items[0] = '{code_unit: REPLACEMENT_UNIT, run_last: 1'b0,
						string_end: 1'b0};
					res.items[1] = '{code_unit: start_unit, run_last: 1'b1,
						string_end: 1'b1};
				end else begin
					kind_next = KIND_THREE_SECOND;
				end
			end
			KIND_THREE_SECOND: begin
				res.count = 2'd1;
				res.items[0] = '{code_unit: {held_lead_q[3:0], held_second_q[5:0],
					item_s1.in_byte[5:0]}, run_last: 1'b1,
					string_end: item_s1.string_last};
			end
			default: begin
				kind_next = start_kind;
				res.count = {1'b0, start_emit};
				res.items[0] = '{code_unit: start_unit, run_last: 1'b1,
					string_end: item_s1.string_last};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (advance) begin
			kind_q <= kind_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && kind_q == KIND_NONE) begin
			held_lead_q <= item_s1.in_byte;
		end
		if (advance && kind_q == KIND_THREE) begin
			held_second_q <= item_s1.in_byte;
		end
	end

endmodule

FILE: sv/u8u16_out_buf.sv
// Two-entry result register that drives the code unit channel.
module u8u16_out_buf
	import u8u16_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_cnt,
	input  out_item_t [MAX_RESULTS - 1:0] push_items,
	output logic [1:0]                    free,
	u8u16_stream_if.source                units
);

	out_item_t  slot_q [MAX_RESULTS];
	logic [1:0] count_q;
	logic       head_q;
	logic       tail;
	logic       pop;

	assign pop = units.valid && units.ready;
	assign tail = head_q ^ count_q[0];
	assign free = (2'd2 - count_q) + {1'b0, pop};
	assign units.valid = (count_q != 2'd0);
	assign units.payload = slot_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			head_q <= 1'b0;
		end else begin
			count_q <= count_q - {1'b0, pop} + push_cnt;
			if (pop) begin
				head_q <= ~head_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			slot_q[tail] <= push_items[0];
		end
		if (push_cnt == 2'd2) begin
			slot_q[~tail] <= push_items[1];
		end
	end

endmodule

FILE: sv/utf8_to_utf16_decoder_unit.sv
// Top level of the UTF-8 to UTF-16 decoder unit.
//
// Channel   Direction  Payload
// bytes     in         in_byte[7:0], string_last
// units     out        code_unit[15:0], run_last, string_end
//
// An accepted byte passes through the input register and then the result
// register on its way to the output. The unit accepts a byte every cycle while
// the units channel does not stall; a byte's two code units are stored together.
// Reset clears the held-sequence state and the result register.
// Stalls on the code unit channel back up through the input register.
module utf8_to_utf16_decoder_unit
	import u8u16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	u8u16_stream_if.sink   bytes,
	u8u16_stream_if.source units
);

	in_item_t   item_s1;
	logic       valid_s1;
	logic       advance;
	dec_res_t   res;
	logic [1:0] free;
	logic [1:0] push_cnt;

	assign advance = valid_s1 && (res.count <= free);
	assign bytes.ready = !valid_s1 || advance;
	assign push_cnt = advance ? res.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1 <= bytes.payload;
		end
	end

	u8u16_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.res     (res)
	);

	u8u16_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_items (res.items),
		.free       (free),
		.units      (units)
	);

	// A transaction that produced results must show up at the output next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd0 |=> units.valid)
		else $error("decoded results did not reach the output");

	// The first of two results is never the end of a run or of the string.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.count == 2'd2 |-> !res.items[0].run_last && !res.items[0].string_end)
		else $error("first of two results carries an end flag");

	// An accepted byte always occupies the input register in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		bytes.valid && bytes.ready |=> valid_s1)
		else $error("accepted byte lost before decoding");

endmodule
